// ===== sv/pec_pkg.sv =====
// ----------------------------------------------------------------------------
// pec_pkg: shared types and constants for the pixel event centroid block
// Configuration record, register indexes, default geometry and width helpers.
// ----------------------------------------------------------------------------
package pec_pkg;

   localparam int GRID_ROWS_DEF     = 4;
   localparam int GRID_COLS_DEF     = 4;
   localparam int WIN_COL_FIRST_DEF = 1;
   localparam int WIN_COL_END_DEF   = 4;
   localparam int WIN_ROW_FIRST_DEF = 0;
   localparam int WIN_ROW_END_DEF   = 3;

   localparam int QUAL_W  = 7;
   localparam int POS_W   = 2;
   localparam int CSR_W   = 7;
   localparam int CSR_IDX_W = 3;

   localparam logic [QUAL_W-1:0] CHER_MASK_RST   = 7'b0111001;
   localparam logic [QUAL_W-1:0] VETO_MASK_RST   = 7'b1000000;
   localparam logic [QUAL_W-1:0] NOPULSE_MASK_RST = 7'b0010000;
   localparam logic [POS_W-1:0]  CHER_ROW_RST    = 2'd3;
   localparam logic [POS_W-1:0]  CHER_COL_RST    = 2'd3;
   localparam logic [POS_W-1:0]  REF_COL_RST     = 2'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHER_MASK    = 3'd0,
      REG_VETO_MASK    = 3'd1,
      REG_NOPULSE_MASK = 3'd2,
      REG_CHER_ROW     = 3'd3,
      REG_CHER_COL     = 3'd4,
      REG_REF_COL      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [QUAL_W-1:0] cher_mask;
      logic [QUAL_W-1:0] veto_mask;
      logic [QUAL_W-1:0] nopulse_mask;
      logic [POS_W-1:0]  cher_row;
      logic [POS_W-1:0]  cher_col;
      logic [POS_W-1:0]  ref_col;
   } cfg_type;

   // weight sum width: 16-bit samples over one event's pixels
   function automatic int sum_width(input int rows, input int cols);
      return 16 + $clog2(rows * cols);
   endfunction

   // weight times (2k+1) with k up to 15
   function automatic int coord_width(input int rows, input int cols);
      return sum_width(rows, cols) + 5;
   endfunction

   // sum of weight times 17-bit signed time difference
   function automatic int dt_width(input int rows, input int cols);
      return 34 + $clog2(rows * cols);
   endfunction

   function automatic int rec_width(input int rows, input int cols);
      return 2 + 4 * sum_width(rows, cols) + 4 * coord_width(rows, cols)
             + 2 * dt_width(rows, cols) + 34;
   endfunction

endpackage

// ===== sv/pec_if.sv =====
// ----------------------------------------------------------------------------
// pec_req_if / pec_rsp_if: pixel and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pec_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         pixel_row;
   logic [1:0]         pixel_col;
   logic [15:0]        pulse_amplitude;
   logic [15:0]        pulse_integral;
   logic signed [15:0] arrival_time;
   logic [6:0]         quality_word;
   logic               last_pixel;

   modport source (output valid, pixel_row, pixel_col, pulse_amplitude, pulse_integral,
                   arrival_time, quality_word, last_pixel, input ready);
   modport sink   (input valid, pixel_row, pixel_col, pulse_amplitude, pulse_integral,
                   arrival_time, quality_word, last_pixel, output ready);
endinterface

interface pec_rsp_if;
   logic               valid;
   logic               ready;
   logic               event_accepted;
   logic [11:0]        amp_centroid_x;
   logic [11:0]        amp_centroid_y;
   logic               amp_centroid_ok;
   logic [11:0]        int_centroid_x;
   logic [11:0]        int_centroid_y;
   logic               int_centroid_ok;
   logic signed [16:0] weighted_dt_amp;
   logic signed [16:0] weighted_dt_int;
   logic signed [16:0] peak_dt_amp;
   logic signed [16:0] peak_dt_int;
   logic [1:0]         timing_flags;

   modport source (output valid, event_accepted, amp_centroid_x, amp_centroid_y,
                   amp_centroid_ok, int_centroid_x, int_centroid_y, int_centroid_ok,
                   weighted_dt_amp, weighted_dt_int, peak_dt_amp, peak_dt_int,
                   timing_flags, input ready);
   modport sink   (input valid, event_accepted, amp_centroid_x, amp_centroid_y,
                   amp_centroid_ok, int_centroid_x, int_centroid_y, int_centroid_ok,
                   weighted_dt_amp, weighted_dt_int, peak_dt_amp, peak_dt_int,
                   timing_flags, output ready);
endinterface

// ===== sv/pec_front.sv =====
// ----------------------------------------------------------------------------
// pec_front: per-pixel classification and event accumulation
// Vetoes, window centroid sums, per-row timing sums merged on row close.
// ----------------------------------------------------------------------------
module pec_front
   import pec_pkg::*;
#(
   parameter int GRID_ROWS     = GRID_ROWS_DEF,
   parameter int GRID_COLS     = GRID_COLS_DEF,
   parameter int WIN_COL_FIRST = WIN_COL_FIRST_DEF,
   parameter int WIN_COL_END   = WIN_COL_END_DEF,
   parameter int WIN_ROW_FIRST = WIN_ROW_FIRST_DEF,
   parameter int WIN_ROW_END   = WIN_ROW_END_DEF,
   parameter int REC_W         = rec_width(GRID_ROWS, GRID_COLS)
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   pec_req_if.sink          req,
   output logic             q_push,
   output logic [REC_W-1:0] q_data,
   input  logic             q_ready
);

   localparam int W_W  = sum_width(GRID_ROWS, GRID_COLS);
   localparam int CW   = coord_width(GRID_ROWS, GRID_COLS);
   localparam int DT_W = dt_width(GRID_ROWS, GRID_COLS);

   typedef struct packed {
      logic                   veto;
      logic [W_W-1:0]         ca_w;
      logic [CW-1:0]          ca_x;
      logic [CW-1:0]          ca_y;
      logic [W_W-1:0]         ci_w;
      logic [CW-1:0]          ci_x;
      logic [CW-1:0]          ci_y;
      logic [W_W-1:0]         amp_sum;
      logic [W_W-1:0]         int_sum;
      logic signed [DT_W-1:0] amp_dt;
      logic signed [DT_W-1:0] int_dt;
      logic                   pk_amp_nz;
      logic signed [16:0]     pk_dt_amp;
      logic signed [16:0]     pk_dt_int;
   } rec_type;

   // event state
   logic                   veto_ff, veto_in;
   logic [W_W-1:0]         ca_w_ff, ca_w_in, ci_w_ff, ci_w_in;
   logic [CW-1:0]          ca_x_ff, ca_x_in, ca_y_ff, ca_y_in;
   logic [CW-1:0]          ci_x_ff, ci_x_in, ci_y_ff, ci_y_in;
   logic [W_W-1:0]         amp_sum_ff, amp_sum_in, int_sum_ff, int_sum_in;
   logic signed [DT_W-1:0] amp_dt_ff, amp_dt_in, int_dt_ff, int_dt_in;
   logic [15:0]            pk_amp_ff, pk_amp_in, pk_int_ff, pk_int_in;
   logic signed [16:0]     pk_dt_amp_ff, pk_dt_amp_in, pk_dt_int_ff, pk_dt_int_in;
   logic                   flush_ff, flush_in;
   // open row state
   logic                   row_open_ff, row_open_in, ref_valid_ff, ref_valid_in;
   logic [1:0]             row_id_ff, row_id_in;
   logic signed [15:0]     ref_time_ff, ref_time_in;
   logic [QUAL_W-1:0]      ref_q_ff, ref_q_in;
   logic [W_W-1:0]         r_amp_ff, r_amp_in, r_int_ff, r_int_in;
   logic signed [DT_W-1:0] r_amp_t_ff, r_amp_t_in, r_int_t_ff, r_int_t_in;
   logic [15:0]            r_pk_amp_ff, r_pk_amp_in, r_pk_int_ff, r_pk_int_in;
   logic signed [15:0]     r_pk_amp_t_ff, r_pk_amp_t_in, r_pk_int_t_ff, r_pk_int_t_in;

   logic                   accept, flush_go, new_row, close_en, close_ok, in_win;
   logic [4:0]             row_off, col_off, wx, wy;
   logic [20:0]            amp_wx, amp_wy, int_wx, int_wy;
   logic signed [32:0]     amp_t, int_t;
   logic signed [DT_W-1:0] ref_x_amp, ref_x_int;
   logic signed [16:0]     cl_dt_amp, cl_dt_int;
   rec_type                rec;

   assign req.ready = !flush_ff;
   assign accept    = req.valid && !flush_ff;
   assign flush_go  = flush_ff && q_ready;
   assign q_push    = flush_go;
   assign q_data    = rec;

   assign new_row  = !row_open_ff || (row_id_ff != req.pixel_row);
   assign close_en = (accept && new_row) || flush_go;
   assign close_ok = row_open_ff && ref_valid_ff && (ref_q_ff == '0);

   assign row_off = 5'({3'b000, req.pixel_row} - 5'(WIN_ROW_FIRST));
   assign col_off = 5'({3'b000, req.pixel_col} - 5'(WIN_COL_FIRST));
   assign wx      = {col_off[3:0], 1'b1};
   assign wy      = {row_off[3:0], 1'b1};
   assign in_win  = ({3'b000, req.pixel_row} >= 5'(WIN_ROW_FIRST))
                 && ({3'b000, req.pixel_row} <  5'(WIN_ROW_END))
                 && ({3'b000, req.pixel_col} >= 5'(WIN_COL_FIRST))
                 && ({3'b000, req.pixel_col} <  5'(WIN_COL_END));

   assign amp_wx = req.pulse_amplitude * wx;
   assign amp_wy = req.pulse_amplitude * wy;
   assign int_wx = req.pulse_integral * wx;
   assign int_wy = req.pulse_integral * wy;
   assign amp_t  = $signed({1'b0, req.pulse_amplitude}) * req.arrival_time;
   assign int_t  = $signed({1'b0, req.pulse_integral}) * req.arrival_time;

   assign ref_x_amp = ref_time_ff * $signed({1'b0, r_amp_ff});
   assign ref_x_int = ref_time_ff * $signed({1'b0, r_int_ff});
   assign cl_dt_amp = 17'(r_pk_amp_t_ff) - 17'(ref_time_ff);
   assign cl_dt_int = 17'(r_pk_int_t_ff) - 17'(ref_time_ff);

   always_comb begin
      veto_in = veto_ff;
      ca_w_in = ca_w_ff; ca_x_in = ca_x_ff; ca_y_in = ca_y_ff;
      ci_w_in = ci_w_ff; ci_x_in = ci_x_ff; ci_y_in = ci_y_ff;
      amp_sum_in = amp_sum_ff; int_sum_in = int_sum_ff;
      amp_dt_in = amp_dt_ff; int_dt_in = int_dt_ff;
      pk_amp_in = pk_amp_ff; pk_int_in = pk_int_ff;
      pk_dt_amp_in = pk_dt_amp_ff; pk_dt_int_in = pk_dt_int_ff;
      flush_in = flush_ff;
      row_open_in = row_open_ff; ref_valid_in = ref_valid_ff; row_id_in = row_id_ff;
      ref_time_in = ref_time_ff; ref_q_in = ref_q_ff;
      r_amp_in = r_amp_ff; r_int_in = r_int_ff;
      r_amp_t_in = r_amp_t_ff; r_int_t_in = r_int_t_ff;
      r_pk_amp_in = r_pk_amp_ff; r_pk_int_in = r_pk_int_ff;
      r_pk_amp_t_in = r_pk_amp_t_ff; r_pk_int_t_in = r_pk_int_t_ff;

      // merge the closing row only when its reference pixel was clean
      if (close_en && close_ok) begin
         amp_sum_in = amp_sum_ff + r_amp_ff;
         int_sum_in = int_sum_ff + r_int_ff;
         amp_dt_in  = amp_dt_ff + (r_amp_t_ff - ref_x_amp);
         int_dt_in  = int_dt_ff + (r_int_t_ff - ref_x_int);
         if (r_pk_amp_ff > pk_amp_ff) begin
            pk_amp_in = r_pk_amp_ff; pk_dt_amp_in = cl_dt_amp;
         end
         if (r_pk_int_ff > pk_int_ff) begin
            pk_int_in = r_pk_int_ff; pk_dt_int_in = cl_dt_int;
         end
      end
      if (close_en) begin
         row_open_in = 1'b0; ref_valid_in = 1'b0; row_id_in = '0;
         ref_time_in = '0; ref_q_in = '0;
         r_amp_in = '0; r_int_in = '0; r_amp_t_in = '0; r_int_t_in = '0;
         r_pk_amp_in = '0; r_pk_int_in = '0; r_pk_amp_t_in = '0; r_pk_int_t_in = '0;
      end

      rec.veto      = veto_ff;
      rec.ca_w      = ca_w_ff; rec.ca_x = ca_x_ff; rec.ca_y = ca_y_ff;
      rec.ci_w      = ci_w_ff; rec.ci_x = ci_x_ff; rec.ci_y = ci_y_ff;
      rec.amp_sum   = amp_sum_in;
      rec.int_sum   = int_sum_in;
      rec.amp_dt    = amp_dt_in;
      rec.int_dt    = int_dt_in;
      rec.pk_amp_nz = (pk_amp_in != '0);
      rec.pk_dt_amp = pk_dt_amp_in;
      rec.pk_dt_int = pk_dt_int_in;

      if (accept) begin
         if (((req.quality_word & cfg.veto_mask) != '0)
             || ((req.pixel_row == cfg.cher_row) && (req.pixel_col == cfg.cher_col)
                 && ((req.quality_word & cfg.cher_mask) != '0)))
            veto_in = 1'b1;
         row_open_in = 1'b1;
         row_id_in   = req.pixel_row;
         if (req.pixel_col == cfg.ref_col) begin
            ref_valid_in = 1'b1;
            ref_time_in  = req.arrival_time;
            ref_q_in     = req.quality_word;
         end
         if (in_win) begin
            if ((req.quality_word & cfg.nopulse_mask) == '0) begin
               ca_w_in = ca_w_ff + W_W'(req.pulse_amplitude);
               ca_x_in = ca_x_ff + CW'(amp_wx);
               ca_y_in = ca_y_ff + CW'(amp_wy);
               ci_w_in = ci_w_ff + W_W'(req.pulse_integral);
               ci_x_in = ci_x_ff + CW'(int_wx);
               ci_y_in = ci_y_ff + CW'(int_wy);
            end
            if (req.quality_word == '0) begin
               r_amp_in   = r_amp_in + W_W'(req.pulse_amplitude);
               r_int_in   = r_int_in + W_W'(req.pulse_integral);
               r_amp_t_in = r_amp_t_in + DT_W'(amp_t);
               r_int_t_in = r_int_t_in + DT_W'(int_t);
               if (req.pulse_amplitude > r_pk_amp_in) begin
                  r_pk_amp_in = req.pulse_amplitude; r_pk_amp_t_in = req.arrival_time;
               end
               if (req.pulse_integral > r_pk_int_in) begin
                  r_pk_int_in = req.pulse_integral; r_pk_int_t_in = req.arrival_time;
               end
            end
         end
         if (req.last_pixel)
            flush_in = 1'b1;
      end

      // hand the event over and start clean
      if (flush_go) begin
         flush_in = 1'b0; veto_in = 1'b0;
         ca_w_in = '0; ca_x_in = '0; ca_y_in = '0;
         ci_w_in = '0; ci_x_in = '0; ci_y_in = '0;
         amp_sum_in = '0; int_sum_in = '0; amp_dt_in = '0; int_dt_in = '0;
         pk_amp_in = '0; pk_int_in = '0; pk_dt_amp_in = '0; pk_dt_int_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         veto_ff <= 1'b0; flush_ff <= 1'b0;
         ca_w_ff <= '0; ca_x_ff <= '0; ca_y_ff <= '0;
         ci_w_ff <= '0; ci_x_ff <= '0; ci_y_ff <= '0;
         amp_sum_ff <= '0; int_sum_ff <= '0; amp_dt_ff <= '0; int_dt_ff <= '0;
         pk_amp_ff <= '0; pk_int_ff <= '0; pk_dt_amp_ff <= '0; pk_dt_int_ff <= '0;
         row_open_ff <= 1'b0; ref_valid_ff <= 1'b0; row_id_ff <= '0;
         ref_time_ff <= '0; ref_q_ff <= '0;
         r_amp_ff <= '0; r_int_ff <= '0; r_amp_t_ff <= '0; r_int_t_ff <= '0;
         r_pk_amp_ff <= '0; r_pk_int_ff <= '0; r_pk_amp_t_ff <= '0; r_pk_int_t_ff <= '0;
      end else begin
         veto_ff <= veto_in; flush_ff <= flush_in;
         ca_w_ff <= ca_w_in; ca_x_ff <= ca_x_in; ca_y_ff <= ca_y_in;
         ci_w_ff <= ci_w_in; ci_x_ff <= ci_x_in; ci_y_ff <= ci_y_in;
         amp_sum_ff <= amp_sum_in; int_sum_ff <= int_sum_in;
         amp_dt_ff <= amp_dt_in; int_dt_ff <= int_dt_in;
         pk_amp_ff <= pk_amp_in; pk_int_ff <= pk_int_in;
         pk_dt_amp_ff <= pk_dt_amp_in; pk_dt_int_ff <= pk_dt_int_in;
         row_open_ff <= row_open_in; ref_valid_ff <= ref_valid_in; row_id_ff <= row_id_in;
         ref_time_ff <= ref_time_in; ref_q_ff <= ref_q_in;
         r_amp_ff <= r_amp_in; r_int_ff <= r_int_in;
         r_amp_t_ff <= r_amp_t_in; r_int_t_ff <= r_int_t_in;
         r_pk_amp_ff <= r_pk_amp_in; r_pk_int_ff <= r_pk_int_in;
         r_pk_amp_t_ff <= r_pk_amp_t_in; r_pk_int_t_ff <= r_pk_int_t_in;
      end
   end

endmodule

// ===== sv/pec_fifo.sv =====
// ----------------------------------------------------------------------------
// pec_fifo: two-entry event record queue
// Decouples pixel accumulation from the division back end.
// ----------------------------------------------------------------------------
module pec_fifo
   import pec_pkg::*;
#(
   parameter int WIDTH = rec_width(GRID_ROWS_DEF, GRID_COLS_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, do_push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0; rd_ptr_ff <= 1'b0; count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in; rd_ptr_ff <= rd_ptr_in; count_ff <= count_in;
      end
   end

endmodule

// ===== sv/pec_div.sv =====
// ----------------------------------------------------------------------------
// pec_div: iterative unsigned restoring divider
// Two quotient bits per step; the owner sequences load and step.
// ----------------------------------------------------------------------------
module pec_div
   import pec_pkg::*;
#(
   parameter int NUM_W = 38,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   localparam int QW = 2 * ((NUM_W + 1) / 2);

   logic [QW-1:0]    q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff;

   assign quo = q_ff[NUM_W-1:0];

   always_comb begin
      logic [DEN_W:0] trial;
      rem_in = rem_ff;
      q_in   = q_ff;
      for (int i = 0; i < 2; i++) begin
         trial = {rem_in, q_in[QW-1]};
         q_in  = {q_in[QW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial   = trial - {1'b0, den_ff};
            q_in[0] = 1'b1;
         end
         rem_in = trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         q_ff   <= QW'(num);
         rem_ff <= '0;
         den_ff <= den;
      end else if (step) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== sv/pec_back.sv =====
// ----------------------------------------------------------------------------
// pec_back: per-event division and result register
// Runs six dividers side by side, then rounds, saturates and signs results.
// ----------------------------------------------------------------------------
module pec_back
   import pec_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF,
   parameter int REC_W     = rec_width(GRID_ROWS, GRID_COLS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  logic [REC_W-1:0] q_data,
   output logic             q_pop,
   pec_rsp_if.source        rsp
);

   localparam int W_W   = sum_width(GRID_ROWS, GRID_COLS);
   localparam int CW    = coord_width(GRID_ROWS, GRID_COLS);
   localparam int DT_W  = dt_width(GRID_ROWS, GRID_COLS);
   localparam int NUM_W = DT_W;
   localparam int DEN_W = W_W + 1;
   localparam int STEPS = (NUM_W + 1) / 2;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int NDIV  = 6;
   localparam int D_AX = 0, D_AY = 1, D_IX = 2, D_IY = 3, D_TA = 4, D_TI = 5;

   typedef struct packed {
      logic                   veto;
      logic [W_W-1:0]         ca_w;
      logic [CW-1:0]          ca_x;
      logic [CW-1:0]          ca_y;
      logic [W_W-1:0]         ci_w;
      logic [CW-1:0]          ci_x;
      logic [CW-1:0]          ci_y;
      logic [W_W-1:0]         amp_sum;
      logic [W_W-1:0]         int_sum;
      logic signed [DT_W-1:0] amp_dt;
      logic signed [DT_W-1:0] int_dt;
      logic                   pk_amp_nz;
      logic signed [16:0]     pk_dt_amp;
      logic signed [16:0]     pk_dt_int;
   } rec_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   typedef struct packed {
      logic veto, a_zero, i_zero, a_ok, i_ok, asum_zero, isum_zero;
      logic sign_a, sign_i, pk_amp_nz;
      logic signed [16:0] pk_dt_amp, pk_dt_int;
   } hold_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   hold_type           hold_ff, hold_in;
   rec_type            rec;
   logic               load, step, out_free, out_load;
   logic [NUM_W-1:0]   num_arr [NDIV];
   logic [DEN_W-1:0]   den_arr [NDIV];
   logic [NUM_W-1:0]   quo_arr [NDIV];
   logic [DT_W-1:0]    mag_a, mag_i;
   logic               out_valid_ff;
   logic [11:0]        ax_ff, ay_ff, ix_ff, iy_ff;
   logic signed [16:0] wa_ff, wi_ff, pa_ff, pi_ff;
   logic               acc_ff, aok_ff, iok_ff;
   logic [1:0]         flags_ff;

   function automatic logic [11:0] sat12(input logic [NUM_W-1:0] v);
      return (v > NUM_W'(4095)) ? 12'd4095 : v[11:0];
   endfunction

   function automatic logic [NUM_W-1:0] cnum(input logic [CW-1:0] s, input logic [W_W-1:0] w);
      return NUM_W'({s, 10'b0}) + NUM_W'({s, 9'b0}) + NUM_W'(w);
   endfunction

   assign rec      = q_data;
   assign load     = (state_ff == ST_IDLE) && q_valid;
   assign q_pop    = load;
   assign step     = (state_ff == ST_RUN);
   assign out_free = !out_valid_ff || rsp.ready;
   assign out_load = (state_ff == ST_HOLD) && out_free;

   assign mag_a = rec.amp_dt[DT_W-1] ? DT_W'(-rec.amp_dt) : DT_W'(rec.amp_dt);
   assign mag_i = rec.int_dt[DT_W-1] ? DT_W'(-rec.int_dt) : DT_W'(rec.int_dt);

   always_comb begin
      num_arr[D_AX] = cnum(rec.ca_x, rec.ca_w);
      num_arr[D_AY] = cnum(rec.ca_y, rec.ca_w);
      num_arr[D_IX] = cnum(rec.ci_x, rec.ci_w);
      num_arr[D_IY] = cnum(rec.ci_y, rec.ci_w);
      num_arr[D_TA] = mag_a;
      num_arr[D_TI] = mag_i;
      den_arr[D_AX] = {rec.ca_w, 1'b0};
      den_arr[D_AY] = {rec.ca_w, 1'b0};
      den_arr[D_IX] = {rec.ci_w, 1'b0};
      den_arr[D_IY] = {rec.ci_w, 1'b0};
      den_arr[D_TA] = DEN_W'(rec.amp_sum);
      den_arr[D_TI] = DEN_W'(rec.int_sum);
   end

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      pec_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
         .clock (clock),
         .load  (load),
         .step  (step),
         .num   (num_arr[g]),
         .den   (den_arr[g]),
         .quo   (quo_arr[g])
      );
   end

   always_comb begin
      hold_in = hold_ff;
      if (load) begin
         hold_in.veto      = rec.veto;
         hold_in.a_zero    = (rec.ca_w == '0);
         hold_in.i_zero    = (rec.ci_w == '0);
         // a centroid exactly at 9 mm in x or 15 mm in y is flagged invalid
         hold_in.a_ok      = (rec.ca_w != '0) && (rec.ca_x != CW'({rec.ca_w, 1'b0}) + CW'(rec.ca_w))
                             && (rec.ca_y != CW'({rec.ca_w, 2'b0}) + CW'(rec.ca_w));
         hold_in.i_ok      = (rec.ci_w != '0) && (rec.ci_x != CW'({rec.ci_w, 1'b0}) + CW'(rec.ci_w))
                             && (rec.ci_y != CW'({rec.ci_w, 2'b0}) + CW'(rec.ci_w));
         hold_in.asum_zero = (rec.amp_sum == '0);
         hold_in.isum_zero = (rec.int_sum == '0);
         hold_in.sign_a    = rec.amp_dt[DT_W-1];
         hold_in.sign_i    = rec.int_dt[DT_W-1];
         hold_in.pk_amp_nz = rec.pk_amp_nz;
         hold_in.pk_dt_amp = rec.pk_dt_amp;
         hold_in.pk_dt_int = rec.pk_dt_int;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1))
               state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (out_load)
            out_valid_ff <= 1'b1;
         else if (rsp.ready)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (out_load) begin
         acc_ff   <= !hold_ff.veto;
         ax_ff    <= (hold_ff.veto || hold_ff.a_zero) ? '0 : sat12(quo_arr[D_AX]);
         ay_ff    <= (hold_ff.veto || hold_ff.a_zero) ? '0 : sat12(quo_arr[D_AY]);
         ix_ff    <= (hold_ff.veto || hold_ff.i_zero) ? '0 : sat12(quo_arr[D_IX]);
         iy_ff    <= (hold_ff.veto || hold_ff.i_zero) ? '0 : sat12(quo_arr[D_IY]);
         aok_ff   <= !hold_ff.veto && hold_ff.a_ok;
         iok_ff   <= !hold_ff.veto && hold_ff.i_ok;
         wa_ff    <= (hold_ff.veto || hold_ff.asum_zero) ? '0 :
                     (hold_ff.sign_a ? -$signed(quo_arr[D_TA][16:0])
                                     : $signed(quo_arr[D_TA][16:0]));
         wi_ff    <= (hold_ff.veto || hold_ff.isum_zero) ? '0 :
                     (hold_ff.sign_i ? -$signed(quo_arr[D_TI][16:0])
                                     : $signed(quo_arr[D_TI][16:0]));
         pa_ff    <= hold_ff.veto ? '0 : hold_ff.pk_dt_amp;
         pi_ff    <= hold_ff.veto ? '0 : hold_ff.pk_dt_int;
         flags_ff <= hold_ff.veto ? 2'b00 : {hold_ff.pk_amp_nz, !hold_ff.asum_zero};
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.event_accepted  = acc_ff;
   assign rsp.amp_centroid_x  = ax_ff;
   assign rsp.amp_centroid_y  = ay_ff;
   assign rsp.amp_centroid_ok = aok_ff;
   assign rsp.int_centroid_x  = ix_ff;
   assign rsp.int_centroid_y  = iy_ff;
   assign rsp.int_centroid_ok = iok_ff;
   assign rsp.weighted_dt_amp = wa_ff;
   assign rsp.weighted_dt_int = wi_ff;
   assign rsp.peak_dt_amp     = pa_ff;
   assign rsp.peak_dt_int     = pi_ff;
   assign rsp.timing_flags    = flags_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("queue popped while dividers busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff < CNT_W'(STEPS)))
      else $error("divider step count overran");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff)
      else $error("result lost after load");
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == ST_RUN) && (cnt_ff == '0))
      else $error("division did not start after pop");

endmodule

// ===== sv/pixel_event_centroid_timing.sv =====
// ----------------------------------------------------------------------------
// pixel_event_centroid_timing: event centroid and timing extraction
// Top level: configuration registers, pixel front end, queue, divider back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one pixel per transfer in raster order; last_pixel marks
//   the end of an event. rsp_bus delivers one result per event. csr_* writes
//   the six configuration registers (index as listed in pec_pkg) and should
//   only be used while no event is in flight.
// Throughput: one pixel per cycle inside an event; after each last pixel
//   req_bus.ready is low while the final row closes and the event record is
//   pushed. The back end takes one event at a time and divides it in STEPS
//   steps, STEPS = ceil(DT_W / 2) (19 for a 4x4 grid), two quotient bits each.
// Path: with an empty queue and an idle back end, the last pixel is followed
//   by push, pop, divider steps, hold, then rsp_bus.valid from its register.
// Stall: when rsp is not taken the result register holds, the two-entry queue
//   fills, and then req_bus.ready drops on the cycle after a last pixel until
//   a queue slot frees.
// Reset: synchronous; clears all event and row state, the queue and the output
//   valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module pixel_event_centroid_timing
   import pec_pkg::*;
#(
   parameter int GRID_ROWS     = GRID_ROWS_DEF,
   parameter int GRID_COLS     = GRID_COLS_DEF,
   parameter int WIN_COL_FIRST = WIN_COL_FIRST_DEF,
   parameter int WIN_COL_END   = WIN_COL_END_DEF,
   parameter int WIN_ROW_FIRST = WIN_ROW_FIRST_DEF,
   parameter int WIN_ROW_END   = WIN_ROW_END_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   pec_req_if.sink              req_bus,
   pec_rsp_if.source            rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   localparam int REC_W = rec_width(GRID_ROWS, GRID_COLS);

   cfg_type          cfg_ff, cfg_in;
   logic             push, push_ready, pop, pop_valid;
   logic [REC_W-1:0] push_data, pop_data;

   // register bank; unknown indexes drop the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_CHER_MASK:    cfg_in.cher_mask    = csr_write_data;
            REG_VETO_MASK:    cfg_in.veto_mask    = csr_write_data;
            REG_NOPULSE_MASK: cfg_in.nopulse_mask = csr_write_data;
            REG_CHER_ROW:     cfg_in.cher_row     = csr_write_data[POS_W-1:0];
            REG_CHER_COL:     cfg_in.cher_col     = csr_write_data[POS_W-1:0];
            REG_REF_COL:      cfg_in.ref_col      = csr_write_data[POS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cher_mask    <= CHER_MASK_RST;
         cfg_ff.veto_mask    <= VETO_MASK_RST;
         cfg_ff.nopulse_mask <= NOPULSE_MASK_RST;
         cfg_ff.cher_row     <= CHER_ROW_RST;
         cfg_ff.cher_col     <= CHER_COL_RST;
         cfg_ff.ref_col      <= REF_COL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify and accumulate each pixel transfer
   pec_front #(
      .GRID_ROWS     (GRID_ROWS),
      .GRID_COLS     (GRID_COLS),
      .WIN_COL_FIRST (WIN_COL_FIRST),
      .WIN_COL_END   (WIN_COL_END),
      .WIN_ROW_FIRST (WIN_ROW_FIRST),
      .WIN_ROW_END   (WIN_ROW_END),
      .REC_W         (REC_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req     (req_bus),
      .q_push  (push),
      .q_data  (push_data),
      .q_ready (push_ready)
   );

   // queue: hold finished event records while the back end divides
   pec_fifo #(.WIDTH(REC_W)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // back: divide, round and register the result
   pec_back #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS),
      .REC_W     (REC_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_bus)
   );

endmodule
